FILE: rtl/core/assert_macros.svh
// Assertion macros used by the sorted list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SLE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("sorted list engine assertion failed");
`define SLE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("sorted list engine assertion failed");
`else
`define SLE_ASSERT(lbl, prop)
`define SLE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/core/sle_pkg.sv
`timescale 1ns / 1ps
package sle_pkg;

	localparam int unsigned VALUE_W = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2,
		OP_POP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic en;
		op_t  op;
	} cell_ctl_t;

	typedef struct packed {
		logic ins;
		logic hit;
	} cell_flag_t;

endpackage

FILE: rtl/core/sle_cell.sv
`timescale 1ns / 1ps
module sle_cell (
	input  logic               clk,
	input  sle_pkg::cell_ctl_t ctl,
	input  sle_pkg::value_t    value,
	input  logic               occ,
	input  logic               left_ins,
	input  sle_pkg::value_t    left_data,
	input  sle_pkg::value_t    right_data,
	output sle_pkg::cell_flag_t flag,
	output sle_pkg::value_t    data
);
	import sle_pkg::*;

	value_t entry_q;
	value_t entry_d;
	logic   ge;

	assign ge       = (entry_q >= value);
	assign flag.ins = !occ || ge;
	assign flag.hit = occ && (entry_q == value);
	assign data     = entry_q;

	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			OP_INSERT: begin
				if (left_ins)
					entry_d = left_data;
				else if (flag.ins)
					entry_d = value;
			end
			OP_DELETE: begin
				if (flag.ins)
					entry_d = right_data;
			end
			OP_POP: entry_d = right_data;
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en)
			entry_q <= entry_d;
	end

endmodule

FILE: rtl/core/sorted_list_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Sorted store of up to CAPACITY signed 32-bit values held in a row of cells, one entry per
// cell. Every cell compares its entry with the incoming value in the same cycle and takes
// its own entry, the value, or a neighbor's entry, so an insert, search, delete or pop
// finishes in the cycle it is accepted and its single result beat sits in an output
// register. One item is accepted per cycle while the result beat is taken; the result beat
// appears in the cycle after the input beat. The longest path is the 32-bit compare in each
// cell followed by the found reduction across the row.
module sorted_list_engine #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sle_pkg::op_t     op,
	input  sle_pkg::value_t  value,
	output logic             out_valid,
	input  logic             out_ready,
	output sle_pkg::status_t status,
	output sle_pkg::value_t  result_value,
	output logic [4:0]       entry_count
);
	import sle_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          out_valid_q;
	status_t       status_q;
	value_t        result_q;
	logic [CW-1:0] ecount_q;

	logic          accept;
	logic          found;
	logic          full;
	logic          empty;
	logic          update;
	status_t       status_d;
	value_t        result_d;
	cell_ctl_t     ctl;

	logic       [CAPACITY-1:0] occ;
	logic       [CAPACITY-1:0] hit;
	cell_flag_t [CAPACITY-1:0] flags;
	value_t     [CAPACITY-1:0] cdata;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign found    = |hit;

	always_comb begin
		update   = 1'b0;
		count_d  = count_q;
		status_d = ST_OK;
		result_d = value;
		case (op)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					update  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_SEARCH: begin
				if (!found)
					status_d = ST_NOT_FOUND;
			end
			OP_DELETE: begin
				if (found) begin
					update  = 1'b1;
					count_d = count_q - 1'b1;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
					result_d = '0;
				end else begin
					update   = 1'b1;
					count_d  = count_q - 1'b1;
					result_d = cdata[0];
				end
			end
			default: update = 1'b0;
		endcase
	end

	assign ctl.en = accept && update;
	assign ctl.op = op;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   left_ins;
		value_t left_data;
		value_t right_data;

		assign occ[i] = (count_q > CW'(i));
		assign hit[i] = flags[i].hit;

		if (i == 0) begin : g_head
			assign left_ins  = 1'b0;
			assign left_data = value;
		end else begin : g_body
			assign left_ins  = flags[i-1].ins;
			assign left_data = cdata[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_data = cdata[i];
		end else begin : g_inner
			assign right_data = cdata[i+1];
		end

		sle_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.value      (value),
			.occ        (occ[i]),
			.left_ins   (left_ins),
			.left_data  (left_data),
			.right_data (right_data),
			.flag       (flags[i]),
			.data       (cdata[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			result_q <= result_d;
			ecount_q <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign entry_count  = 5'(ecount_q);

	`SLE_ASSERT(a_count_bound, count_q <= CW'(CAPACITY))
	`SLE_ASSERT(a_count_hold, !accept |=> $stable(count_q))
	`SLE_ASSERT(a_pop_empty, accept && op == OP_POP && empty |=> status_q == ST_EMPTY)
	`SLE_ASSERT(a_full_hold, accept && op == OP_INSERT && full |=> count_q == CW'(CAPACITY))
	`SLE_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid_q && count_q == '0)

endmodule
